@@ rtl/core/ctc_pkg.sv @@
package ctc_pkg;

    localparam int unsigned MIN_W  = 6;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [3:0] {
        ST_INIT      = 4'd0,
        ST_OFF       = 4'd1,
        ST_WAKE      = 4'd2,
        ST_SET       = 4'd3,
        ST_SET_DIM   = 4'd4,
        ST_COUNT     = 4'd5,
        ST_COUNT_DIM = 4'd6,
        ST_FINISHED  = 4'd7,
        ST_ALERT     = 4'd8
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_DRAW_BLUE   = 3'd1,
        ACT_DIFF_BLUE   = 3'd2,
        ACT_CIRCLES_RED = 3'd3,
        ACT_DIFF_RED    = 3'd4,
        ACT_CLEAR       = 3'd5,
        ACT_ALERT       = 3'd6
    } action_t;

    typedef enum logic [IDX_W-1:0] {
        REG_START_MINUTES   = 3'd0,
        REG_MINUTES_LIMIT   = 3'd1,
        REG_WAKE_TICKS      = 3'd2,
        REG_IDLE_TICKS      = 3'd3,
        REG_MINUTE_TICKS    = 3'd4,
        REG_ALERT_OFF_TICKS = 3'd5,
        REG_BLINK_TICKS     = 3'd6
    } reg_index_t;

    localparam logic [MIN_W-1:0]  RST_START_MINUTES   = 6'd25;
    localparam logic [MIN_W-1:0]  RST_MINUTES_LIMIT   = 6'd60;
    localparam logic [TICK_W-1:0] RST_WAKE_TICKS      = 16'd12;
    localparam logic [TICK_W-1:0] RST_IDLE_TICKS      = 16'd750;
    localparam logic [TICK_W-1:0] RST_MINUTE_TICKS    = 16'd50;
    localparam logic [TICK_W-1:0] RST_ALERT_OFF_TICKS = 16'd3000;
    localparam logic [TICK_W-1:0] RST_BLINK_TICKS     = 16'd50;
    localparam logic [MIN_W-1:0]  RST_SET_MINUTES     = 6'd25;

    typedef struct packed {
        logic [MIN_W-1:0]  start_minutes;
        logic [MIN_W-1:0]  minutes_limit;
        logic [TICK_W-1:0] wake_ticks;
        logic [TICK_W-1:0] idle_ticks;
        logic [TICK_W-1:0] minute_ticks;
        logic [TICK_W-1:0] alert_off_ticks;
        logic [TICK_W-1:0] blink_ticks;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic              long_press;
        logic              press;
        logic signed [6:0] turn_delta;
    } in_item_t;

    typedef struct packed {
        state_t            fsm_state;
        logic              powered;
        logic              bright;
        action_t           display_action;
        logic [MIN_W-1:0]  display_value;
        logic              led_pulse;
    } result_t;

endpackage

@@ rtl/core/ctc_cfg_regs.sv @@
module ctc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ctc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ctc_pkg::TICK_W-1:0]  cfg_data,
    output ctc_pkg::cfg_t               cfg
);

    ctc_pkg::cfg_t cfg_reg;
    ctc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ctc_pkg::REG_START_MINUTES:
                    cfg_next.start_minutes = cfg_data[ctc_pkg::MIN_W-1:0];
                ctc_pkg::REG_MINUTES_LIMIT:
                    cfg_next.minutes_limit = cfg_data[ctc_pkg::MIN_W-1:0];
                ctc_pkg::REG_WAKE_TICKS:      cfg_next.wake_ticks      = cfg_data;
                ctc_pkg::REG_IDLE_TICKS:      cfg_next.idle_ticks      = cfg_data;
                ctc_pkg::REG_MINUTE_TICKS:    cfg_next.minute_ticks    = cfg_data;
                ctc_pkg::REG_ALERT_OFF_TICKS: cfg_next.alert_off_ticks = cfg_data;
                ctc_pkg::REG_BLINK_TICKS:     cfg_next.blink_ticks     = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_minutes   <= ctc_pkg::RST_START_MINUTES;
            cfg_reg.minutes_limit   <= ctc_pkg::RST_MINUTES_LIMIT;
            cfg_reg.wake_ticks      <= ctc_pkg::RST_WAKE_TICKS;
            cfg_reg.idle_ticks      <= ctc_pkg::RST_IDLE_TICKS;
            cfg_reg.minute_ticks    <= ctc_pkg::RST_MINUTE_TICKS;
            cfg_reg.alert_off_ticks <= ctc_pkg::RST_ALERT_OFF_TICKS;
            cfg_reg.blink_ticks     <= ctc_pkg::RST_BLINK_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/ctc_fsm.sv @@
module ctc_fsm #(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctc_pkg::cfg_t      cfg,
    input  logic               step_en,
    input  ctc_pkg::in_item_t  item,
    output ctc_pkg::result_t   result
);

    localparam int unsigned CB   = COUNTER_BITS;
    localparam int unsigned CMPW = (CB > ctc_pkg::TICK_W) ? CB : ctc_pkg::TICK_W;
    localparam int unsigned MW   = ctc_pkg::MIN_W;

    ctc_pkg::state_t mode_reg, mode_next;
    logic [CB-1:0]   wake_count_reg, wake_count_next;
    logic [CB-1:0]   idle_count_reg, idle_count_next;
    logic [CB-1:0]   minute_count_reg, minute_count_next;
    logic [CB-1:0]   blink_count_reg, blink_count_next;
    logic [MW-1:0]   set_minutes_reg, set_minutes_next;
    logic [MW-1:0]   remaining_reg, remaining_next;
    logic            alert_phase_reg, alert_phase_next;
    logic            power_on_reg, power_on_next;
    logic            bright_on_reg, bright_on_next;

    ctc_pkg::action_t act;
    logic [MW-1:0]    val;
    logic             led;
    logic signed [MW+1:0] sum;

    function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
        return (c == {CB{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic reached(input logic [CB-1:0] c,
                                     input logic [ctc_pkg::TICK_W-1:0] lim);
        return CMPW'(c) >= CMPW'(lim);
    endfunction

    // Encoder sum: set minutes plus the signed delta, clamped to max and then to zero.
    assign sum = $signed({2'b00, set_minutes_reg}) + (MW+2)'(item.turn_delta);

    always_comb
    begin
        mode_next         = mode_reg;
        wake_count_next   = wake_count_reg;
        idle_count_next   = idle_count_reg;
        minute_count_next = minute_count_reg;
        blink_count_next  = blink_count_reg;
        set_minutes_next  = set_minutes_reg;
        remaining_next    = remaining_reg;
        alert_phase_next  = alert_phase_reg;
        power_on_next     = power_on_reg;
        bright_on_next    = bright_on_reg;
        act               = ctc_pkg::ACT_NONE;
        val               = '0;
        led               = 1'b0;

        if (item.cmd)
        begin
            if (mode_reg == ctc_pkg::ST_OFF)
            begin
                wake_count_next = '0;
                mode_next       = ctc_pkg::ST_WAKE;
            end
        end
        else if (item.long_press)
        begin
            power_on_next = 1'b0;
            mode_next     = ctc_pkg::ST_OFF;
        end
        else
        begin
            case (mode_reg)
                ctc_pkg::ST_WAKE:
                    wake_count_next = bump(wake_count_reg);
                ctc_pkg::ST_SET, ctc_pkg::ST_SET_DIM:
                    idle_count_next = bump(idle_count_reg);
                ctc_pkg::ST_COUNT:
                begin
                    minute_count_next = bump(minute_count_reg);
                    idle_count_next   = bump(idle_count_reg);
                end
                ctc_pkg::ST_COUNT_DIM:
                    minute_count_next = bump(minute_count_reg);
                ctc_pkg::ST_FINISHED:
                    blink_count_next = bump(blink_count_reg);
                ctc_pkg::ST_ALERT:
                begin
                    minute_count_next = bump(minute_count_reg);
                    blink_count_next  = bump(blink_count_reg);
                end
                default: ;
            endcase

            case (mode_reg)
                ctc_pkg::ST_OFF: ;
                ctc_pkg::ST_WAKE:
                begin
                    if (item.press)
                    begin
                        power_on_next   = 1'b1;
                        idle_count_next = '0;
                        bright_on_next  = 1'b1;
                        act             = ctc_pkg::ACT_DRAW_BLUE;
                        val             = set_minutes_reg;
                        mode_next       = ctc_pkg::ST_SET;
                    end
                    else if (reached(wake_count_next, cfg.wake_ticks))
                    begin
                        mode_next = ctc_pkg::ST_OFF;
                    end
                end
                ctc_pkg::ST_SET, ctc_pkg::ST_SET_DIM:
                begin
                    if (item.press)
                    begin
                        minute_count_next = '0;
                        idle_count_next   = '0;
                        bright_on_next    = 1'b1;
                        act               = ctc_pkg::ACT_CIRCLES_RED;
                        val               = set_minutes_reg;
                        remaining_next    = set_minutes_reg;
                        mode_next         = ctc_pkg::ST_COUNT;
                    end
                    else if (item.turn_delta != '0)
                    begin
                        if (sum > $signed({2'b00, cfg.minutes_limit}))
                            set_minutes_next = cfg.minutes_limit;
                        else if (sum < 0)
                            set_minutes_next = '0;
                        else
                            set_minutes_next = sum[MW-1:0];
                        act             = ctc_pkg::ACT_DIFF_BLUE;
                        val             = set_minutes_next;
                        idle_count_next = '0;
                        bright_on_next  = 1'b1;
                        mode_next       = ctc_pkg::ST_SET;
                    end
                    else if (reached(idle_count_next, cfg.idle_ticks))
                    begin
                        if (mode_reg == ctc_pkg::ST_SET)
                        begin
                            bright_on_next  = 1'b0;
                            idle_count_next = '0;
                            mode_next       = ctc_pkg::ST_SET_DIM;
                        end
                        else
                        begin
                            power_on_next = 1'b0;
                            mode_next     = ctc_pkg::ST_OFF;
                        end
                    end
                end
                ctc_pkg::ST_COUNT, ctc_pkg::ST_COUNT_DIM:
                begin
                    if (reached(minute_count_next, cfg.minute_ticks))
                    begin
                        if (remaining_reg != '0)
                            remaining_next = remaining_reg - 1'b1;
                        minute_count_next = '0;
                        act               = ctc_pkg::ACT_DIFF_RED;
                        val               = remaining_next;
                    end
                    if (remaining_next == '0 || item.press)
                    begin
                        if (mode_reg == ctc_pkg::ST_COUNT)
                            minute_count_next = '0;
                        blink_count_next = '0;
                        mode_next        = ctc_pkg::ST_FINISHED;
                    end
                    else if (mode_reg == ctc_pkg::ST_COUNT)
                    begin
                        if (reached(idle_count_next, cfg.idle_ticks))
                        begin
                            bright_on_next = 1'b0;
                            mode_next      = ctc_pkg::ST_COUNT_DIM;
                        end
                    end
                    else if (item.turn_delta != '0)
                    begin
                        bright_on_next  = 1'b1;
                        idle_count_next = '0;
                        mode_next       = ctc_pkg::ST_COUNT;
                    end
                end
                ctc_pkg::ST_FINISHED:
                begin
                    if (reached(blink_count_next, cfg.blink_ticks) || item.press)
                    begin
                        minute_count_next = '0;
                        blink_count_next  = '0;
                        act               = ctc_pkg::ACT_CLEAR;
                        bright_on_next    = 1'b1;
                        alert_phase_next  = 1'b1;
                        mode_next         = ctc_pkg::ST_ALERT;
                    end
                    else if (item.turn_delta != '0)
                    begin
                        bright_on_next = 1'b1;
                    end
                end
                ctc_pkg::ST_ALERT:
                begin
                    if (item.press)
                    begin
                        idle_count_next = '0;
                        act             = ctc_pkg::ACT_DRAW_BLUE;
                        val             = set_minutes_reg;
                        mode_next       = ctc_pkg::ST_SET;
                    end
                    else if (reached(minute_count_next, cfg.alert_off_ticks))
                    begin
                        power_on_next = 1'b0;
                        mode_next     = ctc_pkg::ST_OFF;
                    end
                    else if (reached(blink_count_next, cfg.blink_ticks))
                    begin
                        blink_count_next = '0;
                        act              = ctc_pkg::ACT_ALERT;
                        val              = MW'(alert_phase_reg);
                        alert_phase_next = ~alert_phase_reg;
                        // The LED flashes as the phase falls back to zero.
                        led              = alert_phase_reg;
                    end
                end
                default:
                begin
                    // Init, and any code outside the state list, loads the defaults.
                    set_minutes_next = cfg.start_minutes;
                    idle_count_next  = '0;
                    bright_on_next   = 1'b1;
                    act              = ctc_pkg::ACT_DRAW_BLUE;
                    val              = cfg.start_minutes;
                    mode_next        = ctc_pkg::ST_SET;
                end
            endcase
        end
    end

    assign result.fsm_state      = mode_next;
    assign result.powered        = power_on_next;
    assign result.bright         = bright_on_next;
    assign result.display_action = act;
    assign result.display_value  = val;
    assign result.led_pulse      = led;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= ctc_pkg::ST_INIT;
            wake_count_reg   <= '0;
            idle_count_reg   <= '0;
            minute_count_reg <= '0;
            blink_count_reg  <= '0;
            set_minutes_reg  <= ctc_pkg::RST_SET_MINUTES;
            remaining_reg    <= '0;
            alert_phase_reg  <= 1'b0;
            power_on_reg     <= 1'b1;
            bright_on_reg    <= 1'b1;
        end
        else if (step_en)
        begin
            mode_reg         <= mode_next;
            wake_count_reg   <= wake_count_next;
            idle_count_reg   <= idle_count_next;
            minute_count_reg <= minute_count_next;
            blink_count_reg  <= blink_count_next;
            set_minutes_reg  <= set_minutes_next;
            remaining_reg    <= remaining_next;
            alert_phase_reg  <= alert_phase_next;
            power_on_reg     <= power_on_next;
            bright_on_reg    <= bright_on_next;
        end
    end

endmodule

@@ rtl/core/countdown_timer_controller_unit.sv @@
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata: long_press, press, turn_delta;
//                                             s_tuser: cmd
// m_*       out        m_tvalid / m_tready    m_tdata: fsm_state, powered, bright,
//                                             display_value, led_pulse;
//                                             m_tuser: display_action
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each word passes an input register and a result register: its result is loaded into the
// result register when the word advances, which waits while the output is stalled. One word
// is accepted every cycle while m_tready is high.
// The state step is combinational compare and saturating increment logic.
// A stalled output holds its result; the input register keeps accepting while it is
// empty. Reset clears both pipeline valid flags and loads the register defaults.
module countdown_timer_controller_unit #(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // long_press, press, turn_delta[6:0], zeros
    input  logic [0:0]                  s_tuser,   // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // fsm_state[3:0], powered, bright,
                                                   // display_value[5:0], led_pulse, zeros
    output logic [2:0]                  m_tuser,   // display_action[2:0]
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ctc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ctc_pkg::TICK_W-1:0]  cfg_data
);

    ctc_pkg::cfg_t     cfg;
    ctc_pkg::in_item_t in_item_reg;
    ctc_pkg::in_item_t in_item_next;
    logic              in_valid_reg;
    ctc_pkg::result_t  step_result;
    ctc_pkg::result_t  out_result_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_item_next.cmd        = s_tuser[0];
    assign in_item_next.long_press = s_tdata[0];
    assign in_item_next.press      = s_tdata[1];
    assign in_item_next.turn_delta = s_tdata[8:2];

    ctc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctc_fsm #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_item_reg <= in_item_next;
        if (advance)
            out_result_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.led_pulse,
                       out_result_reg.display_value,
                       out_result_reg.bright,
                       out_result_reg.powered,
                       out_result_reg.fsm_state};
    assign m_tuser  = out_result_reg.display_action;

endmodule

@@ rtl/core/ctc_checker.sv @@
module ctc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // An LED flash only comes with an alert word that shows phase one.
    a_led_alert: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |->
            m_tuser == ctc_pkg::ACT_ALERT && m_tdata[11:6] == 6'd1)
        else $error("LED pulse outside an alert toggle");

    a_draw_powered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ctc_pkg::ACT_NONE |-> m_tdata[4])
        else $error("display action while powered down");

    a_off_unpowered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == ctc_pkg::ST_OFF |-> !m_tdata[4])
        else $error("off state reported as powered");

endmodule

bind countdown_timer_controller_unit ctc_checker u_ctc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
